>>> src/rpmc_pkg.sv
// Shared constants, codes and types for the randomized Prim maze carver.
// No dependencies; every other file of the block imports this package.
package rpmc_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int X_W        = $clog2(MAX_WIDTH);
	localparam int Y_W        = $clog2(MAX_HEIGHT);
	localparam int CELL_W     = X_W + Y_W;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int CNT_W      = CELL_W + 1;
	localparam int DIM_W      = 7;
	localparam int PICK_W     = 16;

	// Operation codes of a request beat
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Status codes of a response beat
	localparam logic [1:0] ST_CARVED = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_SKIP   = 2'd2;
	localparam logic [1:0] ST_READ   = 2'd3;

	// Configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Directions of a cell two away, in scan order
	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [X_W-1:0]    pos_x;
		logic [Y_W-1:0]    pos_y;
		logic [PICK_W-1:0] wall_pick;
		logic [PICK_W-1:0] neighbour_pick;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [X_W-1:0]   carved_x;
		logic [Y_W-1:0]   carved_y;
		logic [CNT_W-1:0] list_count;
		logic             cell_open;
	} rsp_t;

	typedef struct packed {
		logic              start;
		logic [PICK_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] rem;
	} div_rsp_t;

endpackage

>>> src/rpmc_ifs.sv
// Handshake channels of the maze carver: request, response and configuration.
// Depends on rpmc_pkg for field widths.
interface rpmc_req_if import rpmc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [X_W-1:0]    pos_x;
	logic [Y_W-1:0]    pos_y;
	logic [PICK_W-1:0] wall_pick;
	logic [PICK_W-1:0] neighbour_pick;
	modport source(output valid, op, pos_x, pos_y, wall_pick, neighbour_pick, input ready);
	modport sink(input valid, op, pos_x, pos_y, wall_pick, neighbour_pick, output ready);
endinterface

interface rpmc_rsp_if import rpmc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [X_W-1:0]   carved_x;
	logic [Y_W-1:0]   carved_y;
	logic [CNT_W-1:0] list_count;
	logic             cell_open;
	modport source(output valid, status, carved_x, carved_y, list_count, cell_open, input ready);
	modport sink(input valid, status, carved_x, carved_y, list_count, cell_open, output ready);
endinterface

interface rpmc_cfg_if import rpmc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             idx;
	logic [DIM_W-1:0] data;
	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface

>>> src/rpmc_mod_unit.sv
// Iterative remainder unit: 16-bit dividend modulo a 13-bit divisor, one bit a cycle.
// Depends on rpmc_pkg for widths and the request/response structs.
module rpmc_mod_unit import rpmc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t div_req,
	output div_rsp_t div_rsp
);

	logic [CNT_W-1:0]  rem_q;
	logic [PICK_W-1:0] dvd_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [3:0]        bit_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[PICK_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (div_req.start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 4'd1;
				if (bit_q == 4'(PICK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers carry no reset
	always_ff @(posedge clk) begin
		if (div_req.start) begin
			rem_q <= '0;
			dvd_q <= div_req.dividend;
			dsr_q <= div_req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PICK_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[CNT_W-1:0];
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
		end
	end

	assign div_rsp.done = done_q;
	assign div_rsp.rem  = rem_q;

endmodule

>>> src/rpmc_core.sv
// Carving sequencer with the row-wide cell map memory and the frontier list memory.
// Depends on rpmc_pkg; drives the shared remainder unit through div_req/div_rsp.
module rpmc_core import rpmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] dim_w,
	input  logic [DIM_W-1:0] dim_h,
	input  req_t             req_data,
	input  logic             req_fire,
	output logic             idle,
	output rsp_t             rsp_data,
	output logic             rsp_load,
	input  logic             rsp_free,
	output div_req_t         div_req,
	input  div_rsp_t         div_rsp
);

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_RD   = 5'd2;
	localparam logic [4:0] S_RDW  = 5'd3;
	localparam logic [4:0] S_DIVW = 5'd4;
	localparam logic [4:0] S_LRD  = 5'd5;
	localparam logic [4:0] S_LRD2 = 5'd6;
	localparam logic [4:0] S_LWR  = 5'd7;
	localparam logic [4:0] S_SC0  = 5'd8;
	localparam logic [4:0] S_SC1  = 5'd9;
	localparam logic [4:0] S_SC2  = 5'd10;
	localparam logic [4:0] S_SC3  = 5'd11;
	localparam logic [4:0] S_NDIV = 5'd12;
	localparam logic [4:0] S_SETA = 5'd13;
	localparam logic [4:0] S_SETB = 5'd14;
	localparam logic [4:0] S_PUSH = 5'd15;
	localparam logic [4:0] S_DONE = 5'd16;

	// Control state
	logic [4:0]       state_q;
	logic [Y_W-1:0]   clr_row_q;
	logic             clr_init_q;
	logic [CNT_W-1:0] cnt_q;
	logic             want_q;
	logic [1:0]       set_idx_q;
	logic [1:0]       set_n_q;
	logic [3:0]       flags_q;

	// Item payload
	logic [X_W-1:0]      px_q;
	logic [Y_W-1:0]      py_q;
	logic [PICK_W-1:0]   npick_q;
	logic [X_W-1:0]      ex_q;
	logic [Y_W-1:0]      ey_q;
	logic [CELL_W-1:0]   k_q;
	logic [MAX_WIDTH-1:0] up_row_q;
	logic [MAX_WIDTH-1:0] mid_row_q;
	logic [MAX_WIDTH-1:0] mask0_q;
	logic [1:0]          dir_q;
	logic [1:0]          res_status_q;
	logic [X_W-1:0]      res_x_q;
	logic [Y_W-1:0]      res_y_q;
	logic                res_open_q;

	// Memories
	logic [MAX_WIDTH-1:0] map_mem [MAX_HEIGHT];
	logic [CELL_W-1:0]    list_mem [CELLS];
	logic [MAX_WIDTH-1:0] map_rd_q;
	logic [CELL_W-1:0]    list_rd_q;

	logic                 map_we;
	logic [Y_W-1:0]       map_wa;
	logic [MAX_WIDTH-1:0] map_wd;
	logic [Y_W-1:0]       map_ra;
	logic                 list_we;
	logic [CELL_W-1:0]    list_wa;
	logic [CELL_W-1:0]    list_wd;
	logic [CELL_W-1:0]    list_ra;

	// Combinational helpers
	logic [X_W-1:0]       sat_x;
	logic [Y_W-1:0]       sat_y;
	logic                 xl_ok, xr_ok, yu_ok, yd_ok;
	logic [3:0]           scan_flags;
	logic [2:0]           scan_pop;
	logic [1:0]           pick_dir;
	logic [1:0]           seen;
	logic [Y_W-1:0]       set_row;
	logic [MAX_WIDTH-1:0] set_mask;
	logic [1:0]           push_dir;
	logic [X_W-1:0]       push_x;
	logic [Y_W-1:0]       push_y;
	logic [MAX_WIDTH-1:0] bit_ex;

	// Map and list storage, registered read
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd_q <= map_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_wa] <= list_wd;
		end
		list_rd_q <= list_mem[list_ra];
	end

	// Saturate the start cell to the grid in use
	assign sat_x = ({1'b0, req_data.pos_x} >= dim_w) ? X_W'(dim_w - 7'd1) : req_data.pos_x;
	assign sat_y = ({1'b0, req_data.pos_y} >= dim_h) ? Y_W'(dim_h - 7'd1) : req_data.pos_y;

	// Cells two away that lie inside the grid
	assign xl_ok = ex_q > X_W'(1);
	assign xr_ok = ({1'b0, ex_q} + 7'd2) < dim_w;
	assign yu_ok = ey_q > Y_W'(1);
	assign yd_ok = ({1'b0, ey_q} + 7'd2) < dim_h;

	assign scan_flags[DIR_LEFT]  = xl_ok && (mid_row_q[ex_q - X_W'(2)] == want_q);
	assign scan_flags[DIR_RIGHT] = xr_ok && (mid_row_q[ex_q + X_W'(2)] == want_q);
	assign scan_flags[DIR_UP]    = yu_ok && (up_row_q[ex_q] == want_q);
	assign scan_flags[DIR_DOWN]  = yd_ok && (map_rd_q[ex_q] == want_q);
	assign scan_pop = 3'(scan_flags[0]) + 3'(scan_flags[1]) + 3'(scan_flags[2])
		+ 3'(scan_flags[3]);

	assign bit_ex = MAX_WIDTH'(1) << ex_q;

	// Find the set flag that the remainder selects
	always_comb begin
		pick_dir = DIR_LEFT;
		seen     = '0;
		for (int i = 0; i < 4; i++) begin
			if (flags_q[i]) begin
				if (seen == div_rsp.rem[1:0]) begin
					pick_dir = 2'(i);
				end
				seen = seen + 2'd1;
			end
		end
	end

	// Row and mask of each cell-open write
	always_comb begin
		set_row  = ey_q;
		set_mask = bit_ex;
		case (set_idx_q)
			2'd0: begin
				set_row  = ey_q;
				set_mask = mask0_q;
			end
			2'd1: set_row = (dir_q == DIR_UP) ? ey_q - Y_W'(1) : ey_q + Y_W'(1);
			default: set_row = (dir_q == DIR_UP) ? ey_q - Y_W'(2) : ey_q + Y_W'(2);
		endcase
	end

	// Lowest pending frontier push
	always_comb begin
		push_dir = DIR_LEFT;
		if (flags_q[DIR_LEFT]) begin
			push_dir = DIR_LEFT;
		end else if (flags_q[DIR_RIGHT]) begin
			push_dir = DIR_RIGHT;
		end else if (flags_q[DIR_UP]) begin
			push_dir = DIR_UP;
		end else begin
			push_dir = DIR_DOWN;
		end
		push_x = ex_q;
		push_y = ey_q;
		case (push_dir)
			DIR_LEFT:  push_x = ex_q - X_W'(2);
			DIR_RIGHT: push_x = ex_q + X_W'(2);
			DIR_UP:    push_y = ey_q - Y_W'(2);
			default:   push_y = ey_q + Y_W'(2);
		endcase
	end

	// Memory ports and divider launch
	always_comb begin
		map_we           = 1'b0;
		map_wa           = set_row;
		map_wd           = map_rd_q | set_mask;
		map_ra           = ey_q;
		list_we          = 1'b0;
		list_wa          = k_q;
		list_wd          = list_rd_q;
		list_ra          = k_q;
		div_req.start    = 1'b0;
		div_req.dividend = npick_q;
		div_req.divisor  = CNT_W'(scan_pop);
		unique case (state_q)
			S_CLR: begin
				map_we = 1'b1;
				map_wa = clr_row_q;
				map_wd = '0;
			end
			S_IDLE: begin
				div_req.dividend = req_data.wall_pick;
				div_req.divisor  = cnt_q;
				div_req.start    = req_fire && (req_data.op == OP_STEP) && (cnt_q != '0);
			end
			S_RD:   map_ra = py_q;
			S_LRD2: list_ra = CELL_W'(cnt_q - CNT_W'(1));
			S_LWR:  list_we = 1'b1;
			S_SC0:  map_ra = ey_q - Y_W'(2);
			S_SC1:  map_ra = ey_q;
			S_SC2:  map_ra = ey_q + Y_W'(2);
			S_SC3:  div_req.start = want_q && !mid_row_q[ex_q] && (scan_flags != '0);
			S_SETA: map_ra = set_row;
			S_SETB: map_we = 1'b1;
			S_PUSH: begin
				list_wa = cnt_q[CELL_W-1:0];
				list_wd = {push_y, push_x};
				list_we = (flags_q != '0) && (cnt_q < CNT_W'(CELLS));
			end
			S_RDW, S_DIVW, S_LRD, S_NDIV, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_row_q  <= '0;
			clr_init_q <= 1'b1;
			cnt_q      <= '0;
			want_q     <= 1'b0;
			set_idx_q  <= '0;
			set_n_q    <= '0;
			flags_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_row_q <= clr_row_q + Y_W'(1);
					if (clr_row_q == Y_W'(MAX_HEIGHT - 1)) begin
						if (clr_init_q) begin
							clr_init_q <= 1'b0;
							state_q    <= S_IDLE;
						end else begin
							set_idx_q <= '0;
							set_n_q   <= 2'd1;
							state_q   <= S_SETA;
						end
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						case (req_data.op)
							OP_START: begin
								cnt_q     <= '0;
								clr_row_q <= '0;
								state_q   <= S_CLR;
							end
							OP_STEP: begin
								state_q <= (cnt_q == '0) ? S_DONE : S_DIVW;
							end
							OP_READ: state_q <= S_RD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RD:  state_q <= S_RDW;
				S_RDW: state_q <= S_DONE;
				S_DIVW: begin
					if (div_rsp.done) begin
						state_q <= S_LRD;
					end
				end
				S_LRD:  state_q <= S_LRD2;
				S_LRD2: state_q <= S_LWR;
				S_LWR: begin
					cnt_q   <= cnt_q - CNT_W'(1);
					want_q  <= 1'b1;
					state_q <= S_SC0;
				end
				S_SC0: state_q <= S_SC1;
				S_SC1: state_q <= S_SC2;
				S_SC2: state_q <= S_SC3;
				S_SC3: begin
					flags_q <= scan_flags;
					if (!want_q) begin
						state_q <= S_PUSH;
					end else if (mid_row_q[ex_q] || (scan_flags == '0)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_NDIV;
					end
				end
				S_NDIV: begin
					if (div_rsp.done) begin
						set_idx_q <= '0;
						set_n_q   <= (pick_dir == DIR_LEFT || pick_dir == DIR_RIGHT) ? 2'd1 : 2'd3;
						state_q   <= S_SETA;
					end
				end
				S_SETA: state_q <= S_SETB;
				S_SETB: begin
					if (set_idx_q == set_n_q - 2'd1) begin
						want_q  <= 1'b0;
						state_q <= S_SC0;
					end else begin
						set_idx_q <= set_idx_q + 2'd1;
						state_q   <= S_SETA;
					end
				end
				S_PUSH: begin
					if (flags_q == '0) begin
						state_q <= S_DONE;
					end else begin
						flags_q[push_dir] <= 1'b0;
						if (cnt_q < CNT_W'(CELLS)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q         <= req_data.pos_x;
				py_q         <= req_data.pos_y;
				npick_q      <= req_data.neighbour_pick;
				ex_q         <= sat_x;
				ey_q         <= sat_y;
				mask0_q      <= MAX_WIDTH'(1) << sat_x;
				res_status_q <= (req_data.op == OP_STEP) ? ST_EMPTY : ST_CARVED;
				res_x_q      <= (req_data.op == OP_START) ? sat_x : '0;
				res_y_q      <= (req_data.op == OP_START) ? sat_y : '0;
				res_open_q   <= 1'b0;
			end
			S_RDW: begin
				res_status_q <= ST_READ;
				res_open_q   <= ({1'b0, px_q} < dim_w) && ({1'b0, py_q} < dim_h)
					&& map_rd_q[px_q];
			end
			S_DIVW: k_q <= div_rsp.rem[CELL_W-1:0];
			S_LRD2: begin
				ex_q <= list_rd_q[X_W-1:0];
				ey_q <= list_rd_q[CELL_W-1:X_W];
			end
			S_SC1: up_row_q <= map_rd_q;
			S_SC2: mid_row_q <= map_rd_q;
			S_SC3: res_status_q <= want_q ? ST_SKIP : res_status_q;
			S_NDIV: begin
				dir_q        <= pick_dir;
				res_status_q <= ST_CARVED;
				res_x_q      <= ex_q;
				res_y_q      <= ey_q;
				case (pick_dir)
					DIR_LEFT:  mask0_q <= bit_ex | (bit_ex >> 1) | (bit_ex >> 2);
					DIR_RIGHT: mask0_q <= bit_ex | (bit_ex << 1) | (bit_ex << 2);
					default:   mask0_q <= bit_ex;
				endcase
			end
			default: begin
			end
		endcase
	end

	assign idle                = (state_q == S_IDLE);
	assign rsp_load            = (state_q == S_DONE) && rsp_free;
	assign rsp_data.status     = res_status_q;
	assign rsp_data.carved_x   = res_x_q;
	assign rsp_data.carved_y   = res_y_q;
	assign rsp_data.list_count = cnt_q;
	assign rsp_data.cell_open  = res_open_q;

endmodule

>>> src/randomized_prim_maze_carver_top.sv
// Randomized Prim maze carver. After reset, a pass over every map row clears the cell map
// before the first request is taken. Start clears the map again, opens the start cell and
// pushes its blocked cells. Step: a remainder for the frontier pick, one for the neighbour
// pick, then map row reads and writes; an empty list skips both, a skip the second.
// One request is in work at a time; the response register frees the request side.
module randomized_prim_maze_carver_top import rpmc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	rpmc_req_if.sink   req,
	rpmc_rsp_if.source rsp,
	rpmc_cfg_if.sink   cfg
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] dim_w;
	logic [DIM_W-1:0] dim_h;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             core_rsp;
	req_t             req_data;
	logic             core_idle;
	logic             rsp_load;
	logic             rsp_free;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	// Take configuration beats at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(20);
			height_q <= DIM_W'(20);
		end else if (cfg.valid) begin
			case (cfg.idx)
				REG_WIDTH:  width_q  <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Clamp the grid size to the map, a zero size to one
	assign dim_w = (width_q == '0) ? DIM_W'(1) :
		(width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign dim_h = (height_q == '0) ? DIM_W'(1) :
		(height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

	assign req_data.op             = req.op;
	assign req_data.pos_x          = req.pos_x;
	assign req_data.pos_y          = req.pos_y;
	assign req_data.wall_pick      = req.wall_pick;
	assign req_data.neighbour_pick = req.neighbour_pick;
	assign req.ready               = core_idle;

	rpmc_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	rpmc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.dim_w    (dim_w),
		.dim_h    (dim_h),
		.req_data (req_data),
		.req_fire (req.valid && core_idle),
		.idle     (core_idle),
		.rsp_data (core_rsp),
		.rsp_load (rsp_load),
		.rsp_free (rsp_free),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

	// Hold the response beat until taken
	assign rsp_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= core_rsp;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_q.status;
	assign rsp.carved_x   = rsp_q.carved_x;
	assign rsp.carved_y   = rsp_q.carved_y;
	assign rsp.list_count = rsp_q.list_count;
	assign rsp.cell_open  = rsp_q.cell_open;

endmodule

>>> tb/maze_checker.sv
// Checker for the maze carver: watches the request, response and configuration
// channels, predicts each response and compares it field by field.
// Depends on rpmc_pkg and the channel interfaces in rpmc_ifs.
module maze_checker import rpmc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	rpmc_req_if    req,
	rpmc_rsp_if    rsp,
	rpmc_cfg_if    cfg,
	output int     fail_count,
	output int     pending
);

	// Shadow copy of the block's grid, frontier and registers
	logic               grid_open [CELLS];
	logic [CELL_W-1:0]  frontier [CELLS];
	int                 frontier_len;
	logic [DIM_W-1:0]   cols_reg;
	logic [DIM_W-1:0]   rows_reg;
	int                 nb_x [4];
	int                 nb_y [4];
	rsp_t               expected_rsp [$];

	function automatic int clamp_dim(logic [DIM_W-1:0] v, int mx);
		if (v < 1) return 1;
		if (v > mx) return mx;
		return int'(v);
	endfunction

	function automatic int cell_index(int x, int y);
		return (y * MAX_WIDTH + x) % CELLS;
	endfunction

	// Gather cells two away whose open state equals want, in scan order
	function int gather_two_away(int x, int y, bit want);
		int w;
		int h;
		int n;
		w = clamp_dim(cols_reg, MAX_WIDTH);
		h = clamp_dim(rows_reg, MAX_HEIGHT);
		n = 0;
		if (x > 1 && grid_open[cell_index(x - 2, y)] == want) begin
			nb_x[n] = x - 2; nb_y[n] = y; n++;
		end
		if (x + 2 < w && grid_open[cell_index(x + 2, y)] == want) begin
			nb_x[n] = x + 2; nb_y[n] = y; n++;
		end
		if (y > 1 && grid_open[cell_index(x, y - 2)] == want) begin
			nb_x[n] = x; nb_y[n] = y - 2; n++;
		end
		if (y + 2 < h && grid_open[cell_index(x, y + 2)] == want) begin
			nb_x[n] = x; nb_y[n] = y + 2; n++;
		end
		return n;
	endfunction

	function void push_blocked(int x, int y);
		int n;
		n = gather_two_away(x, y, 1'b0);
		for (int i = 0; i < n; i++) begin
			if (frontier_len < CELLS) begin
				frontier[frontier_len] = CELL_W'(cell_index(nb_x[i], nb_y[i]));
				frontier_len++;
			end
		end
	endfunction

	// Advance the shadow state by one request and return the response it causes
	function rsp_t carve_predict(req_t r);
		rsp_t o;
		int w;
		int h;
		int px;
		int py;
		int k;
		int ex;
		int ey;
		int n;
		int j;
		logic [CELL_W-1:0] e;
		o = '0;
		w = clamp_dim(cols_reg, MAX_WIDTH);
		h = clamp_dim(rows_reg, MAX_HEIGHT);
		px = int'(r.pos_x);
		py = int'(r.pos_y);
		if (r.op == OP_START) begin
			for (int i = 0; i < CELLS; i++) grid_open[i] = 1'b0;
			frontier_len = 0;
			if (px >= w) px = w - 1;
			if (py >= h) py = h - 1;
			grid_open[cell_index(px, py)] = 1'b1;
			push_blocked(px, py);
			o.status = ST_CARVED;
			o.carved_x = X_W'(px);
			o.carved_y = Y_W'(py);
		end else if (r.op == OP_STEP) begin
			if (frontier_len == 0) begin
				o.status = ST_EMPTY;
			end else begin
				k = int'(r.wall_pick) % frontier_len;
				e = frontier[k];
				ex = int'(e) % MAX_WIDTH;
				ey = int'(e) / MAX_WIDTH;
				frontier_len--;
				frontier[k] = frontier[frontier_len];
				n = grid_open[cell_index(ex, ey)] ? 0 : gather_two_away(ex, ey, 1'b1);
				if (n == 0) begin
					o.status = ST_SKIP;
				end else begin
					j = int'(r.neighbour_pick) % n;
					grid_open[cell_index(ex, ey)] = 1'b1;
					grid_open[cell_index((ex + nb_x[j]) / 2, (ey + nb_y[j]) / 2)] = 1'b1;
					grid_open[cell_index(nb_x[j], nb_y[j])] = 1'b1;
					push_blocked(ex, ey);
					o.status = ST_CARVED;
					o.carved_x = X_W'(ex);
					o.carved_y = Y_W'(ey);
				end
			end
		end else begin
			o.status = ST_READ;
			o.cell_open = (px < w && py < h && grid_open[cell_index(px, py)]);
		end
		o.list_count = CNT_W'(frontier_len);
		return o;
	endfunction

	task automatic report(string field, int got, int want);
		$display("%0t: response mismatch on %s: got %0h, expected %0h", $realtime, field, got,
			want);
		fail_count++;
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++) grid_open[i] = 1'b0;
		frontier_len = 0;
		cols_reg = DIM_W'(20);
		rows_reg = DIM_W'(20);
		fail_count = 0;
	end

	assign pending = expected_rsp.size();

	// Track register writes and accepted request beats
	always @(posedge clk) begin
		req_t r;
		if (arst_n && cfg.valid && cfg.ready) begin
			if (cfg.idx == REG_WIDTH) cols_reg = cfg.data;
			else rows_reg = cfg.data;
		end
		if (arst_n && req.valid && req.ready && req.op != OP_NONE) begin
			r.op = req.op;
			r.pos_x = req.pos_x;
			r.pos_y = req.pos_y;
			r.wall_pick = req.wall_pick;
			r.neighbour_pick = req.neighbour_pick;
			expected_rsp.push_back(carve_predict(r));
		end
	end

	// Compare each response beat with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: response beat with nothing outstanding", $realtime);
				fail_count++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status) report("status", rsp.status, want.status);
				if (rsp.carved_x !== want.carved_x)
					report("carved_x", rsp.carved_x, want.carved_x);
				if (rsp.carved_y !== want.carved_y)
					report("carved_y", rsp.carved_y, want.carved_y);
				if (rsp.list_count !== want.list_count)
					report("list_count", rsp.list_count, want.list_count);
				if (rsp.cell_open !== want.cell_open)
					report("cell_open", rsp.cell_open, want.cell_open);
			end
		end
	end

endmodule

>>> tb/tb.sv
// Top of the maze carver testbench: clock, reset, request and register
// stimulus, response back-pressure and verdict. Depends on rpmc_pkg,
// rpmc_ifs, the block and maze_checker.
module tb import rpmc_pkg::*; ();

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   gap_pct;
	int   stall_pct;
	bit   hold_req;

	rpmc_req_if req();
	rpmc_rsp_if rsp();
	rpmc_cfg_if cfg();

	randomized_prim_maze_carver_top i_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	maze_checker i_checker (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// Receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		int hold_left;
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_beat(logic [1:0] op, int x, int y, int wp, int np);
		while ($urandom_range(99) < gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.pos_x <= X_W'(x);
		req.pos_y <= Y_W'(y);
		req.wall_pick <= PICK_W'(wp);
		req.neighbour_pick <= PICK_W'(np);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		cfg.valid <= 1'b1;
		cfg.idx <= idx;
		cfg.data <= DIM_W'(val);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly carving steps, some reads, rare restarts and unused codes
	task automatic random_beat();
		int r;
		r = $urandom_range(99);
		if (r < 72)
			send_beat(OP_STEP, 0, 0, $urandom_range(65535), $urandom_range(65535));
		else if (r < 95)
			send_beat(OP_READ, $urandom_range(63), $urandom_range(63), $urandom_range(65535),
				$urandom_range(65535));
		else if (r < 98)
			send_beat(OP_NONE, $urandom_range(63), $urandom_range(63), $urandom_range(65535),
				$urandom_range(65535));
		else
			send_beat(OP_START, $urandom_range(63), $urandom_range(63), 0, 0);
	endtask

	int ph_cols   [10] = '{3, 64, 0, 127, 5, 64, 9, 1, 20, 33};
	int ph_rows   [10] = '{3, 64, 0, 127, 64, 3, 3, 7, 20, 17};
	int ph_beats  [10] = '{60, 800, 20, 250, 150, 150, 60, 40, 220, 200};
	bit ph_resume [10] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0};

	initial begin
		arst_n = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		req.valid = 1'b0;
		req.op = OP_NONE;
		req.pos_x = '0;
		req.pos_y = '0;
		req.wall_pick = '0;
		req.neighbour_pick = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.idx = REG_WIDTH;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats on the reset dimensions
		send_beat(OP_READ, 0, 0, 0, 0);
		send_beat(OP_STEP, 0, 0, 65535, 65535);
		send_beat(OP_NONE, 63, 63, 65535, 65535);
		send_beat(OP_READ, 63, 63, 0, 0);
		send_beat(OP_START, 63, 63, 0, 0);
		send_beat(OP_READ, 19, 19, 0, 0);
		send_beat(OP_STEP, 0, 0, 0, 0);
		send_beat(OP_STEP, 0, 0, 65535, 65535);
		send_beat(OP_READ, 19, 18, 0, 0);
		send_beat(OP_READ, 20, 19, 0, 0);
		send_beat(OP_START, 0, 0, 65535, 65535);
		for (int i = 0; i < 8; i++)
			send_beat(OP_STEP, 0, 0, i[0] ? 65535 : 0, i[1] ? 65535 : 0);
		send_beat(OP_READ, 0, 0, 0, 0);
		send_beat(OP_READ, 0, 63, 0, 0);
		drain();

		// Phases with different dimensions and idling
		for (int p = 0; p < 10; p++) begin
			gap_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 30 : 52) : 0;
			stall_pct = (p % 4 == 2) ? 52 : ((p % 4 == 3) ? 30 : 0);
			write_reg(REG_WIDTH, ph_cols[p]);
			write_reg(REG_HEIGHT, ph_rows[p]);
			if (!ph_resume[p])
				send_beat(OP_START, $urandom_range(63), $urandom_range(63), 0, 0);
			for (int i = 0; i < ph_beats[p]; i++) begin
				if (p == 1 && i == 50) hold_req = 1'b1;
				if (p == 1 && i == 400) begin
					req.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				random_beat();
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("[randomized_prim_maze_carver_top] OK");
		end else begin
			$display("[randomized_prim_maze_carver_top] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#16000000;
		$display("[randomized_prim_maze_carver_top] ERROR");
		$finish;
	end

endmodule

>>> randomized_prim_maze_carver_top.f
src/rpmc_pkg.sv
src/rpmc_ifs.sv
src/rpmc_mod_unit.sv
src/rpmc_core.sv
src/randomized_prim_maze_carver_top.sv
tb/maze_checker.sv
tb/tb.sv
